// File: design/bdq_pkg.sv
package bdq_pkg;

	localparam int DATA_W    = 32;
	localparam int CAP_W     = 5;
	localparam int DEPTH_DEF = 16;
	localparam logic [CAP_W-1:0] CAPACITY_RST = CAP_W'(16);

	localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
	localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
	localparam logic [1:0] OP_POP_FRONT  = 2'd2;
	localparam logic [1:0] OP_POP_BACK   = 2'd3;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// command broadcast to every cell, at most one bit set
	typedef struct packed {
		logic push_front;
		logic push_rear;
		logic pop_front;
		logic pop_back;
	} bdq_cmd_t;

	// one result beat
	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] value;
	} bdq_res_t;

endpackage

// File: design/bdq_cell.sv
module bdq_cell
	import bdq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  bdq_cmd_t          cmd,
	input  logic [DATA_W-1:0] push_value,
	input  logic              occ_prev,
	input  logic [DATA_W-1:0] f_prev,
	input  logic [DATA_W-1:0] b_prev,
	input  logic              occ_next,
	input  logic [DATA_W-1:0] f_next,
	input  logic [DATA_W-1:0] b_next,
	output logic              occ,
	output logic [DATA_W-1:0] f,
	output logic [DATA_W-1:0] b
);

	logic              occ_q;
	logic [DATA_W-1:0] f_q;
	logic [DATA_W-1:0] b_q;
	logic              occ_d;
	logic [DATA_W-1:0] f_d;
	logic [DATA_W-1:0] b_d;
	logic              tail_slot;

	// first free cell after the last held one
	assign tail_slot = occ_prev & ~occ_q;

	always_comb begin
		occ_d = occ_q;
		if (cmd.push_front || cmd.push_rear) begin
			occ_d = occ_prev;
		end else if (cmd.pop_front || cmd.pop_back) begin
			occ_d = occ_next;
		end
	end

	// front-ordered chain
	always_comb begin
		f_d = f_q;
		if (cmd.push_front) begin
			f_d = f_prev;
		end else if (cmd.push_rear && tail_slot) begin
			f_d = push_value;
		end else if (cmd.pop_front) begin
			f_d = f_next;
		end
	end

	// back-ordered chain
	always_comb begin
		b_d = b_q;
		if (cmd.push_rear) begin
			b_d = b_prev;
		end else if (cmd.push_front && tail_slot) begin
			b_d = push_value;
		end else if (cmd.pop_back) begin
			b_d = b_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			occ_q <= occ_d;
		end
	end

	always_ff @(posedge clk) begin
		f_q <= f_d;
		b_q <= b_d;
	end

	assign occ = occ_q;
	assign f   = f_q;
	assign b   = b_q;

endmodule

// File: design/bdq_out.sv
module bdq_out
	import bdq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     res_valid,
	input  bdq_res_t res,
	output logic     res_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output bdq_res_t out_res,
	output logic     skid_busy
);

	logic     out_valid_q;
	bdq_res_t out_q;
	logic     skid_valid_q;
	bdq_res_t skid_q;
	logic     out_free;

	assign res_ready = ~skid_valid_q;
	assign out_free  = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (res_valid && res_ready) begin
				if (out_free) begin
					out_valid_q <= 1'b1;
				end else begin
					skid_valid_q <= 1'b1;
				end
			end else if (out_free) begin
				out_valid_q  <= skid_valid_q;
				skid_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			if (out_free) begin
				out_q <= res;
			end else begin
				skid_q <= res;
			end
		end else if (out_free && skid_valid_q) begin
			out_q <= skid_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign skid_busy = skid_valid_q;

endmodule

// File: design/bounded_double_ended_queue.sv
// channel   | handshake                        | payload
// ----------+----------------------------------+-------------------------------
// command   | in_valid / in_ready              | op[1:0], value[31:0] signed
// result    | out_valid / out_ready            | status[1:0], value_out[31:0]
// capacity  | capacity_valid / capacity_ready  | capacity[4:0]
//
// one command per cycle while in_ready is high; its result is registered
// every command is done by the row of cells, all shifting together
// a two-deep output stage lets a command in while one result still waits
// in_ready drops only when both output slots are taken
// reset empties the queue and sets capacity to 16; capacity_ready is always high
module bounded_double_ended_queue
	import bdq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               op,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic signed [DATA_W-1:0] value_out,
	input  logic                     capacity_valid,
	output logic                     capacity_ready,
	input  logic [CAP_W-1:0]         capacity
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	logic [CAP_W-1:0] capacity_q;
	logic [CNT_W-1:0] count_q;
	logic [LIM_W-1:0] cap_ext;
	logic [LIM_W-1:0] limit;
	logic             full;
	logic             empty;
	logic             in_fire;
	bdq_cmd_t         cmd;
	bdq_res_t         res;
	bdq_res_t         out_res;
	logic             skid_busy;

	logic              occ_c [DEPTH];
	logic [DATA_W-1:0] f_c   [DEPTH];
	logic [DATA_W-1:0] b_c   [DEPTH];
	logic [DEPTH-1:0]  occ_vec;

	assign capacity_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RST;
		end else if (capacity_valid && capacity_ready) begin
			capacity_q <= capacity;
		end
	end

	assign cap_ext = LIM_W'(capacity_q);
	assign limit   = (cap_ext > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : cap_ext;
	assign full    = LIM_W'(count_q) >= limit;
	assign empty   = count_q == '0;
	assign in_fire = in_valid & in_ready;

	always_comb begin
		cmd = '0;
		res = '{status: ST_DONE, value: '0};
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (full) begin
					res.status = ST_FULL;
				end else begin
					res.value = value;
					cmd.push_front = in_fire & (op == OP_PUSH_FRONT);
					cmd.push_rear  = in_fire & (op == OP_PUSH_BACK);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else begin
					res.value = f_c[0];
					cmd.pop_front = in_fire;
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					res.status = ST_EMPTY;
				end else begin
					res.value = b_c[0];
					cmd.pop_back = in_fire;
				end
			end
			default: begin
				res.status = ST_EMPTY;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.push_front || cmd.push_rear) begin
			count_q <= count_q + CNT_W'(1);
		end else if (cmd.pop_front || cmd.pop_back) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic              occ_prev;
		logic [DATA_W-1:0] f_prev;
		logic [DATA_W-1:0] b_prev;
		logic              occ_next;
		logic [DATA_W-1:0] f_next;
		logic [DATA_W-1:0] b_next;

		if (i == 0) begin : g_head
			assign occ_prev = 1'b1;
			assign f_prev   = value;
			assign b_prev   = value;
		end else begin : g_body
			assign occ_prev = occ_c[i-1];
			assign f_prev   = f_c[i-1];
			assign b_prev   = b_c[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign occ_next = 1'b0;
			assign f_next   = '0;
			assign b_next   = '0;
		end else begin : g_mid
			assign occ_next = occ_c[i+1];
			assign f_next   = f_c[i+1];
			assign b_next   = b_c[i+1];
		end

		bdq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.push_value (value),
			.occ_prev   (occ_prev),
			.f_prev     (f_prev),
			.b_prev     (b_prev),
			.occ_next   (occ_next),
			.f_next     (f_next),
			.b_next     (b_next),
			.occ        (occ_c[i]),
			.f          (f_c[i]),
			.b          (b_c[i])
		);

		assign occ_vec[i] = occ_c[i];
	end

	bdq_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (in_valid),
		.res       (res),
		.res_ready (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res),
		.skid_busy (skid_busy)
	);

	assign status    = out_res.status;
	assign value_out = out_res.value;

	a_occ_count : assert property (@(posedge clk) disable iff (!arst_n)
		$countones(occ_vec) == 32'(count_q))
		else $error("cell occupancy disagrees with entry count");

	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= DEPTH)
		else $error("entry count above depth");

	a_skid_order : assert property (@(posedge clk) disable iff (!arst_n)
		skid_busy |-> out_valid)
		else $error("skid slot filled while output slot empty");

	a_refused_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != ST_DONE) |-> value_out == '0)
		else $error("refused beat carries a value");

	a_count_step : assert property (@(posedge clk) disable iff (!arst_n)
		!in_fire |=> $stable(count_q))
		else $error("entry count moved without a command beat");

endmodule
